// ===== rtl/core/sfi_pkg.sv =====
// Shared types and constants for the substring first-index search unit.
`timescale 1ns / 1ps
`default_nettype none

package sfi_pkg;

   localparam int NEEDLE_W     = 64;
   localparam int NEEDLE_BYTES = NEEDLE_W / 8;
   localparam int BYTE_IDX_W   = $clog2(NEEDLE_BYTES);
   localparam int LEN_W        = 4;
   localparam int START_W      = 16;
   localparam int POS_W        = 17;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_BYTES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_INDEX   = 2'd2;

   typedef struct packed {
      logic [NEEDLE_W-1:0] needle;
      logic [LEN_W-1:0]    len_eff;
   } sfi_cfg_type;

   typedef struct packed {
      logic [7:0] win_byte;
      logic       equal;
   } sfi_cell_out_type;

endpackage

`default_nettype wire

// ===== rtl/core/sfi_cell.sv =====
// One window cell: holds a byte of the recent-byte row and compares the incoming byte.
`timescale 1ns / 1ps
`default_nettype none

module sfi_cell
   import sfi_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  wire logic             clock,
   input  wire logic             shift_en,
   input  wire logic [7:0]       shift_in,
   input  wire sfi_cfg_type      cfg,
   output      sfi_cell_out_type cell_out
);

   localparam logic [LEN_W-1:0] CELL_POS = LEN_W'(CELL_INDEX);

   logic [7:0]            byte_ff;
   logic [7:0]            byte_in;
   logic                  active;
   logic [LEN_W-1:0]      sel;
   logic [BYTE_IDX_W-1:0] sel_idx;
   logic [7:0]            want;

   // needle byte k lines up with cell len-1-k
   always_comb begin
      active  = CELL_POS < cfg.len_eff;
      sel     = cfg.len_eff - CELL_POS - LEN_W'(1);
      sel_idx = sel[BYTE_IDX_W-1:0];
      want    = cfg.needle[{sel_idx, 3'b000} +: 8];
      byte_in = shift_en ? shift_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_out.win_byte = byte_ff;
   assign cell_out.equal    = !active || (shift_in == want);

endmodule

`default_nettype wire

// ===== rtl/core/substring_first_index_unit.sv =====
// Top level of the substring first-index search unit.
//
// Streams one string byte per beat and reports, once per string, the first position at or
// after start_index where the needle (up to NEEDLE_MAX bytes) occurs in full; -1 at the final
// beat if there is none, and min(start_index, length) for an empty needle. One byte is taken
// every cycle while input is not stalled: a row of NEEDLE_MAX cells holds the recent bytes and
// compares the incoming one in parallel, and the count and start checks close in the same cycle,
// so a beat's result is written to the output register as that beat is taken. Input is stalled only
// while a result waits in that register and rsp_stall is high. Configuration writes act at once.
`timescale 1ns / 1ps
`default_nettype none

module substring_first_index_unit
   import sfi_pkg::*;
#(
   parameter int NEEDLE_MAX = 8,
   parameter int MAX_LENGTH = 65535
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [NEEDLE_W-1:0]     csr_write_data,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic [7:0]              req_char_byte,
   input  wire logic                    req_no_char,
   input  wire logic                    req_end_of_string,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic                    rsp_found,
   output      logic signed [POS_W-1:0] rsp_match_position
);

   localparam int CNT_W = $clog2(MAX_LENGTH + 1);

   logic [NEEDLE_W-1:0]     needle_ff;
   logic [LEN_W-1:0]        length_ff;
   logic [START_W-1:0]      start_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    reported_ff, reported_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;

   sfi_cfg_type             cfg;
   sfi_cell_out_type        cell_out [NEEDLE_MAX];
   logic [NEEDLE_MAX-1:0]   cell_eq;
   logic                    accept;
   logic                    take;
   logic [POS_W-1:0]        cnt_next;
   logic [POS_W-1:0]        len_ext;
   logic [POS_W-1:0]        start_ext;
   logic [POS_W-1:0]        hit_pos;
   logic                    hit;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign take      = accept && !req_no_char && (count_ff < CNT_W'(MAX_LENGTH));

   assign cfg.needle  = needle_ff;
   assign cfg.len_eff = (length_ff > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX) : length_ff;

   for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
      sfi_cell #(
         .CELL_INDEX(j)
      ) u_cell (
         .clock   (clock),
         .shift_en(take),
         .shift_in((j == 0) ? req_char_byte : cell_out[(j == 0) ? 0 : j - 1].win_byte),
         .cfg     (cfg),
         .cell_out(cell_out[j])
      );
      assign cell_eq[j] = cell_out[j].equal;
   end

   always_comb begin
      cnt_next  = POS_W'(count_ff) + POS_W'(take);
      len_ext   = POS_W'(cfg.len_eff);
      start_ext = POS_W'(start_ff);
      hit_pos   = cnt_next - len_ext;
      hit       = take && !reported_ff && (cfg.len_eff != '0) && (cnt_next >= len_ext)
                  && (hit_pos >= start_ext) && (&cell_eq);

      count_in     = count_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;

      if (accept) begin
         count_in = cnt_next[CNT_W-1:0];
         if (hit) begin
            reported_in  = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b1;
            rsp_pos_in   = hit_pos;
         end else if (req_end_of_string && !reported_ff) begin
            rsp_valid_in = 1'b1;
            if (cfg.len_eff == '0) begin
               rsp_found_in = 1'b1;
               rsp_pos_in   = (start_ext < cnt_next) ? start_ext : cnt_next;
            end else begin
               rsp_found_in = 1'b0;
               rsp_pos_in   = '1;
            end
         end
         if (req_end_of_string) begin
            count_in    = '0;
            reported_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff    <= '0;
         length_ff    <= '0;
         start_ff     <= '0;
         count_ff     <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_NEEDLE_BYTES:  needle_ff <= csr_write_data;
               CSR_NEEDLE_LENGTH: length_ff <= csr_write_data[LEN_W-1:0];
               CSR_START_INDEX:   start_ff  <= csr_write_data[START_W-1:0];
               default: ;
            endcase
         end
         count_ff     <= count_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_match_position = $signed(rsp_pos_ff);

   a_reported_has_bytes : assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> count_ff != '0)
      else $error("reported flag set with empty byte count");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LENGTH))
      else $error("byte count beyond maximum length");

   a_miss_is_minus_one : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> rsp_pos_ff == '1)
      else $error("miss beat without -1 position");

   a_found_non_negative : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> !rsp_pos_ff[POS_W-1])
      else $error("match beat with negative position");

   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_string) |=> (count_ff == '0) && !reported_ff)
      else $error("string state not cleared after final beat");

endmodule

`default_nettype wire
